### hw/rtl/lsrb_pkg.sv
package lsrb_pkg;

    localparam int PERIOD_BITS = 12;
    localparam int ON_BITS     = 10;
    localparam int COL_BITS    = 3;
    localparam int LST_BITS    = 3;
    localparam int LIMIT_BITS  = 16;

    localparam logic [COL_BITS-1:0] COL_R     = 3'b001;
    localparam logic [COL_BITS-1:0] COL_G     = 3'b010;
    localparam logic [COL_BITS-1:0] COL_B     = 3'b100;
    localparam logic [COL_BITS-1:0] COL_AMBER = COL_R | COL_G;
    localparam logic [COL_BITS-1:0] COL_OFF   = 3'b000;

    localparam logic [LST_BITS-1:0] ST_FAULT       = 3'd0;
    localparam logic [LST_BITS-1:0] ST_INVISIBLE   = 3'd1;
    localparam logic [LST_BITS-1:0] ST_ADVERTISING = 3'd2;
    localparam logic [LST_BITS-1:0] ST_LINKING     = 3'd3;
    localparam logic [LST_BITS-1:0] ST_STALLED     = 3'd4;
    localparam logic [LST_BITS-1:0] ST_READY       = 3'd5;

    localparam logic [LIMIT_BITS-1:0] STALL_LIMIT_RESET = 16'd5000;

    localparam logic OP_TICK     = 1'b0;
    localparam logic OP_OVERRIDE = 1'b1;

    typedef struct packed {
        logic [COL_BITS-1:0]    colour;
        logic [ON_BITS-1:0]     on_ms;
        logic [PERIOD_BITS-1:0] period;
    } blink_t;

    typedef struct packed {
        logic busy;
        logic done;
    } mod_stat_t;

    function automatic blink_t blink_lookup(input logic [LST_BITS-1:0] st);
        blink_t b;
        unique case (st)
            ST_FAULT:       b = '{COL_R,     10'd100, 12'd200};
            ST_INVISIBLE:   b = '{COL_R,     10'd100, 12'd1000};
            ST_ADVERTISING: b = '{COL_B,     10'd8,   12'd1500};
            ST_LINKING:     b = '{COL_AMBER, 10'd500, 12'd500};
            ST_STALLED:     b = '{COL_AMBER, 10'd8,   12'd1500};
            ST_READY:       b = '{COL_G,     10'd8,   12'd3000};
            default:        b = '{COL_R,     10'd100, 12'd200};
        endcase
        return b;
    endfunction

endpackage

### hw/rtl/lsrb_in_if.sv
interface lsrb_in_if;
    logic        valid;
    logic        ready;
    logic        op;
    logic [31:0] now_ms;
    logic        radio_active;
    logic        link_ready;
    logic        is_advertising;
    logic        peer_connected;
    logic [31:0] echo_count;
    logic        override_auto;
    logic [7:0]  override_colour;

    modport source (
        output valid, op, now_ms, radio_active, link_ready, is_advertising,
               peer_connected, echo_count, override_auto, override_colour,
        input  ready
    );

    modport sink (
        input  valid, op, now_ms, radio_active, link_ready, is_advertising,
               peer_connected, echo_count, override_auto, override_colour,
        output ready
    );
endinterface

### hw/rtl/lsrb_out_if.sv
interface lsrb_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] led_colour;
    logic       led_write;
    logic [2:0] link_state;
    logic       override_active;

    modport source (
        output valid, led_colour, led_write, link_state, override_active,
        input  ready
    );

    modport sink (
        input  valid, led_colour, led_write, link_state, override_active,
        output ready
    );
endinterface

### hw/rtl/lsrb_mod_unit.sv
module lsrb_mod_unit
    import lsrb_pkg::*;
#(
    parameter int TIME_BITS = 32
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic [TIME_BITS-1:0]   dividend,
    input  logic [PERIOD_BITS-1:0] divisor,
    output logic [PERIOD_BITS-1:0] rem,
    output mod_stat_t              stat
);

    localparam int CNT_BITS = $clog2(TIME_BITS);

    logic [TIME_BITS-1:0]   num_reg, num_next;
    logic [PERIOD_BITS-1:0] rem_reg, rem_next;
    logic [PERIOD_BITS-1:0] div_reg, div_next;
    logic [CNT_BITS-1:0]    cnt_reg, cnt_next;
    logic                   busy_reg, busy_next;
    logic                   done_reg, done_next;

    logic [PERIOD_BITS:0]   trial;
    logic [PERIOD_BITS:0]   diff;

    // restoring remainder, one dividend bit per cycle, MSB first
    assign trial = {rem_reg, num_reg[TIME_BITS-1]};
    assign diff  = trial - {1'b0, div_reg};

    always_comb
    begin
        num_next  = num_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            num_next  = dividend;
            rem_next  = '0;
            div_next  = divisor;
            cnt_next  = CNT_BITS'(TIME_BITS - 1);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            num_next = {num_reg[TIME_BITS-2:0], 1'b0};
            if (trial >= {1'b0, div_reg})
                rem_next = diff[PERIOD_BITS-1:0];
            else
                rem_next = trial[PERIOD_BITS-1:0];
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
    end

    assign rem       = rem_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

### hw/rtl/link_status_rgb_blinker_top.sv
// Status LED driver for a radio link. Each request on items is a service tick
// (op 0) or an override command (op 1) and yields exactly one request on
// results. Override commands and ticks while a colour is forced go from
// classification straight to the result stage; an automatic tick first waits
// on the bit-serial modulo unit that reduces the blink phase by the pattern
// period, one bit per cycle. The result stage holds until results can take
// the result. items is not ready while a request is in work; a finished
// result may wait on results while the next request is taken. stall_limit_ms
// sits at APB byte address 0 and may only be written while the block is idle.
module link_status_rgb_blinker_top
    import lsrb_pkg::*;
#(
    parameter int TIME_BITS = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    lsrb_in_if.sink     items,
    lsrb_out_if.source  results
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_CLASS = 2'd1;
    localparam logic [1:0] S_DIV   = 2'd2;
    localparam logic [1:0] S_FIN   = 2'd3;

    logic [1:0] fsm_reg, fsm_next;

    // configuration
    logic [LIMIT_BITS-1:0] stall_limit_reg;

    // captured request
    logic                 itm_op_reg;
    logic [TIME_BITS-1:0] itm_now_reg;
    logic                 itm_radio_reg;
    logic                 itm_link_reg;
    logic                 itm_adv_reg;
    logic                 itm_peer_reg;
    logic [31:0]          itm_echo_reg;
    logic                 itm_auto_reg;
    logic [COL_BITS-1:0]  itm_colour_reg;

    // block state
    logic [LST_BITS-1:0]  cur_state_reg, cur_state_next;
    logic [TIME_BITS-1:0] phase_start_reg, phase_start_next;
    logic [COL_BITS-1:0]  shown_mask_reg, shown_mask_next;
    logic                 shown_valid_reg, shown_valid_next;
    logic                 forced_on_reg, forced_on_next;
    logic [COL_BITS-1:0]  forced_mask_reg, forced_mask_next;
    logic [31:0]          echo_seen_reg, echo_seen_next;
    logic [TIME_BITS-1:0] adv_time_reg, adv_time_next;
    logic                 adv_armed_reg, adv_armed_next;

    // pattern waiting on the modulo unit
    logic [COL_BITS-1:0]  pend_colour_reg, pend_colour_next;
    logic [ON_BITS-1:0]   pend_on_reg, pend_on_next;

    // result
    logic [COL_BITS-1:0]  res_colour_reg, res_colour_next;
    logic                 res_write_reg, res_write_next;
    logic [LST_BITS-1:0]  res_state_reg, res_state_next;
    logic                 res_ovr_reg, res_ovr_next;

    logic                 out_valid_reg, out_valid_next;
    logic                 out_load;

    logic                 accept;
    logic                 cfg_write;

    logic [LST_BITS-1:0]  st_new;
    logic [TIME_BITS-1:0] stall_elapsed;
    logic [TIME_BITS-1:0] phase_elapsed;
    logic [COL_BITS-1:0]  drive_mask;
    logic                 drive_write;
    blink_t               blink;

    logic                   mod_start;
    logic [PERIOD_BITS-1:0] mod_rem;
    mod_stat_t              mod_stat;

    assign accept    = items.valid && items.ready;
    assign cfg_write = psel && penable && pwrite && !paddr[2];
    assign items.ready = (fsm_reg == S_IDLE);
    assign pready = 1'b1;
    assign prdata = paddr[2] ? 32'd0 : {16'd0, stall_limit_reg};

    lsrb_mod_unit #(
        .TIME_BITS (TIME_BITS)
    ) u_mod (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (mod_start),
        .dividend (phase_elapsed),
        .divisor  (blink.period),
        .rem      (mod_rem),
        .stat     (mod_stat)
    );

    always_comb
    begin
        fsm_next         = fsm_reg;
        cur_state_next   = cur_state_reg;
        phase_start_next = phase_start_reg;
        shown_mask_next  = shown_mask_reg;
        shown_valid_next = shown_valid_reg;
        forced_on_next   = forced_on_reg;
        forced_mask_next = forced_mask_reg;
        echo_seen_next   = echo_seen_reg;
        adv_time_next    = adv_time_reg;
        adv_armed_next   = adv_armed_reg;
        pend_colour_next = pend_colour_reg;
        pend_on_next     = pend_on_reg;
        res_colour_next  = res_colour_reg;
        res_write_next   = res_write_reg;
        res_state_next   = res_state_reg;
        res_ovr_next     = res_ovr_reg;
        mod_start        = 1'b0;
        out_load         = 1'b0;
        st_new           = ST_FAULT;
        stall_elapsed    = '0;
        phase_elapsed    = '0;
        blink            = blink_lookup(cur_state_reg);
        drive_mask       = forced_mask_reg;
        drive_write      = 1'b0;

        unique case (fsm_reg)
            S_IDLE:
            begin
                if (items.valid)
                    fsm_next = S_CLASS;
            end
            S_CLASS:
            begin
                if (itm_op_reg == OP_OVERRIDE)
                begin
                    if (itm_auto_reg)
                    begin
                        forced_on_next   = 1'b0;
                        shown_valid_next = 1'b0;
                        phase_start_next = itm_now_reg;
                    end
                    else
                    begin
                        forced_on_next   = 1'b1;
                        forced_mask_next = itm_colour_reg;
                    end
                    res_colour_next = shown_mask_reg;
                    res_write_next  = 1'b0;
                    res_state_next  = cur_state_reg;
                    res_ovr_next    = forced_on_next;
                    fsm_next        = S_FIN;
                end
                else if (forced_on_reg)
                begin
                    drive_mask  = forced_mask_reg;
                    drive_write = !(shown_valid_reg && drive_mask == shown_mask_reg);
                    if (drive_write)
                    begin
                        shown_mask_next  = drive_mask;
                        shown_valid_next = 1'b1;
                    end
                    res_colour_next = shown_mask_next;
                    res_write_next  = drive_write;
                    res_state_next  = cur_state_reg;
                    res_ovr_next    = 1'b1;
                    fsm_next        = S_FIN;
                end
                else
                begin
                    if (!itm_radio_reg)
                    begin
                        st_new = ST_FAULT;
                    end
                    else if (!itm_link_reg)
                    begin
                        adv_armed_next = 1'b0;
                        if (itm_peer_reg)
                            st_new = ST_LINKING;
                        else if (itm_adv_reg)
                            st_new = ST_ADVERTISING;
                        else
                            st_new = ST_INVISIBLE;
                    end
                    else
                    begin
                        if (itm_echo_reg != echo_seen_reg)
                        begin
                            echo_seen_next = itm_echo_reg;
                            adv_time_next  = itm_now_reg;
                            adv_armed_next = 1'b1;
                        end
                        else if (!adv_armed_reg)
                        begin
                            adv_time_next  = itm_now_reg;
                            adv_armed_next = 1'b1;
                        end
                        stall_elapsed = itm_now_reg - adv_time_next;
                        if (stall_elapsed > TIME_BITS'(stall_limit_reg))
                            st_new = ST_STALLED;
                        else
                            st_new = ST_READY;
                    end
                    if (st_new != cur_state_reg)
                    begin
                        cur_state_next   = st_new;
                        phase_start_next = itm_now_reg;
                        shown_valid_next = 1'b0;
                    end
                    phase_elapsed    = itm_now_reg - phase_start_next;
                    blink            = blink_lookup(cur_state_next);
                    pend_colour_next = blink.colour;
                    pend_on_next     = blink.on_ms;
                    mod_start        = 1'b1;
                    fsm_next         = S_DIV;
                end
            end
            S_DIV:
            begin
                if (mod_stat.done)
                begin
                    drive_mask  = (mod_rem < PERIOD_BITS'(pend_on_reg)) ?
                                  pend_colour_reg : COL_OFF;
                    drive_write = !(shown_valid_reg && drive_mask == shown_mask_reg);
                    if (drive_write)
                    begin
                        shown_mask_next  = drive_mask;
                        shown_valid_next = 1'b1;
                    end
                    res_colour_next = shown_mask_next;
                    res_write_next  = drive_write;
                    res_state_next  = cur_state_reg;
                    res_ovr_next    = 1'b0;
                    fsm_next        = S_FIN;
                end
            end
            S_FIN:
            begin
                if (!out_valid_reg || results.ready)
                begin
                    out_load = 1'b1;
                    fsm_next = S_IDLE;
                end
            end
            default:
            begin
                fsm_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
            out_valid_next = 1'b1;
        else if (results.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fsm_reg         <= S_IDLE;
            stall_limit_reg <= STALL_LIMIT_RESET;
            cur_state_reg   <= ST_FAULT;
            phase_start_reg <= '0;
            shown_mask_reg  <= COL_OFF;
            shown_valid_reg <= 1'b0;
            forced_on_reg   <= 1'b0;
            forced_mask_reg <= COL_OFF;
            echo_seen_reg   <= '0;
            adv_time_reg    <= '0;
            adv_armed_reg   <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            fsm_reg         <= fsm_next;
            if (cfg_write)
                stall_limit_reg <= pwdata[LIMIT_BITS-1:0];
            cur_state_reg   <= cur_state_next;
            phase_start_reg <= phase_start_next;
            shown_mask_reg  <= shown_mask_next;
            shown_valid_reg <= shown_valid_next;
            forced_on_reg   <= forced_on_next;
            forced_mask_reg <= forced_mask_next;
            echo_seen_reg   <= echo_seen_next;
            adv_time_reg    <= adv_time_next;
            adv_armed_reg   <= adv_armed_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            itm_op_reg     <= items.op;
            itm_now_reg    <= TIME_BITS'(items.now_ms);
            itm_radio_reg  <= items.radio_active;
            itm_link_reg   <= items.link_ready;
            itm_adv_reg    <= items.is_advertising;
            itm_peer_reg   <= items.peer_connected;
            itm_echo_reg   <= items.echo_count;
            itm_auto_reg   <= items.override_auto;
            itm_colour_reg <= items.override_colour[COL_BITS-1:0];
        end
        pend_colour_reg <= pend_colour_next;
        pend_on_reg     <= pend_on_next;
        res_colour_reg  <= res_colour_next;
        res_write_reg   <= res_write_next;
        res_state_reg   <= res_state_next;
        res_ovr_reg     <= res_ovr_next;
        if (out_load)
        begin
            results.led_colour      <= res_colour_reg;
            results.led_write       <= res_write_reg;
            results.link_state      <= res_state_reg;
            results.override_active <= res_ovr_reg;
        end
    end

    assign results.valid = out_valid_reg;

    // assertions
    a_accept_to_class: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> fsm_reg == S_CLASS)
        else $error("accepted request did not enter classification");

    a_div_not_forced: assert property (@(posedge clk) disable iff (!rst_n)
        fsm_reg == S_DIV |-> !forced_on_reg)
        else $error("blink phase computed while a colour is forced");

    a_write_sets_shown: assert property (@(posedge clk) disable iff (!rst_n)
        (fsm_reg == S_FIN && res_write_reg) |-> shown_valid_reg)
        else $error("pin write reported without a shown mask");

    a_state_range: assert property (@(posedge clk) disable iff (!rst_n)
        cur_state_reg <= ST_READY)
        else $error("link state out of range");

    a_div_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (fsm_reg == S_DIV && !mod_stat.done) |-> mod_stat.busy)
        else $error("waiting on an idle modulo unit");

endmodule

### test/testbench.sv
module testbench;
    import lsrb_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam logic [2:0] STALL_LIMIT_ADDR = 3'd0;

    typedef struct packed {
        logic        op;
        logic [31:0] now_ms;
        logic        radio_active;
        logic        link_ready;
        logic        is_advertising;
        logic        peer_connected;
        logic [31:0] echo_count;
        logic        override_auto;
        logic [7:0]  override_colour;
    } link_req_t;

    typedef struct packed {
        logic [COL_BITS-1:0] led_colour;
        logic                led_write;
        logic [LST_BITS-1:0] link_state;
        logic                override_active;
    } led_result_t;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    lsrb_in_if  in_if();
    lsrb_out_if out_if();

    link_status_rgb_blinker_top dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .items   (in_if),
        .results (out_if)
    );

    link_req_t   request_q[$];
    led_result_t led_expect_q[$];
    link_req_t   shown_req;

    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;
    int unsigned mismatches;
    int unsigned cfg_errors;
    int unsigned result_idx;
    int unsigned cycle_count;

    // blinker state mirror
    logic [LIMIT_BITS-1:0] stall_limit;
    logic [LST_BITS-1:0]   cur_state;
    logic [31:0]           phase_start;
    logic [COL_BITS-1:0]   shown_mask;
    logic                  shown_valid;
    logic                  forced_on;
    logic [COL_BITS-1:0]   forced_mask;
    logic [31:0]           echo_seen;
    logic [31:0]           advance_time;
    logic                  advance_armed;

    // stimulus generator state
    logic [31:0]         stim_now;
    logic [31:0]         stim_echo;
    logic [LST_BITS-1:0] link_mode;
    int unsigned         echo_rate;

    function automatic logic drive_mask(input logic [COL_BITS-1:0] mask);
        if (shown_valid && mask == shown_mask)
        begin
            return 1'b0;
        end
        shown_mask  = mask;
        shown_valid = 1'b1;
        return 1'b1;
    endfunction

    function automatic led_result_t next_led(input link_req_t r);
        led_result_t         res;
        logic [LST_BITS-1:0] st;
        logic [COL_BITS-1:0] colour;
        logic [31:0]         on_t;
        logic [31:0]         period;
        logic [31:0]         ph;
        logic                wrote;
        wrote = 1'b0;
        if (r.op == OP_OVERRIDE)
        begin
            if (r.override_auto)
            begin
                forced_on   = 1'b0;
                shown_valid = 1'b0;
                phase_start = r.now_ms;
            end
            else
            begin
                forced_on   = 1'b1;
                forced_mask = r.override_colour[2:0];
            end
        end
        else if (forced_on)
        begin
            wrote = drive_mask(forced_mask);
        end
        else
        begin
            if (!r.radio_active)
            begin
                st = ST_FAULT;
            end
            else if (!r.link_ready)
            begin
                advance_armed = 1'b0;
                if (r.peer_connected)
                    st = ST_LINKING;
                else if (r.is_advertising)
                    st = ST_ADVERTISING;
                else
                    st = ST_INVISIBLE;
            end
            else
            begin
                if (r.echo_count != echo_seen)
                begin
                    echo_seen     = r.echo_count;
                    advance_time  = r.now_ms;
                    advance_armed = 1'b1;
                end
                else if (!advance_armed)
                begin
                    advance_time  = r.now_ms;
                    advance_armed = 1'b1;
                end
                st = ((r.now_ms - advance_time) > {16'd0, stall_limit}) ? ST_STALLED : ST_READY;
            end
            if (st != cur_state)
            begin
                cur_state   = st;
                phase_start = r.now_ms;
                shown_valid = 1'b0;
            end
            case (cur_state)
                ST_INVISIBLE:   begin colour = COL_R;     on_t = 100; period = 1000; end
                ST_ADVERTISING: begin colour = COL_B;     on_t = 8;   period = 1500; end
                ST_LINKING:     begin colour = COL_AMBER; on_t = 500; period = 500;  end
                ST_STALLED:     begin colour = COL_AMBER; on_t = 8;   period = 1500; end
                ST_READY:       begin colour = COL_G;     on_t = 8;   period = 3000; end
                default:        begin colour = COL_R;     on_t = 100; period = 200;  end
            endcase
            ph = (r.now_ms - phase_start) % period;
            wrote = drive_mask(ph < on_t ? colour : COL_OFF);
        end
        res.led_colour      = shown_mask;
        res.led_write       = wrote;
        res.link_state      = cur_state;
        res.override_active = forced_on;
        return res;
    endfunction

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            cycle_count <= 0;
        end
        else
        begin
            cycle_count <= cycle_count + 1;
            if (cycle_count == CYCLE_LIMIT)
            begin
                $display("testbench NOT OK");
                $finish;
            end
        end
    end

    // request driver
    always @(posedge clk)
    begin
        logic took;
        took = in_if.valid && in_if.ready;
        if (!rst_n)
        begin
            in_if.valid           <= 1'b0;
            in_if.op              <= OP_TICK;
            in_if.now_ms          <= '0;
            in_if.radio_active    <= 1'b0;
            in_if.link_ready      <= 1'b0;
            in_if.is_advertising  <= 1'b0;
            in_if.peer_connected  <= 1'b0;
            in_if.echo_count      <= '0;
            in_if.override_auto   <= 1'b0;
            in_if.override_colour <= '0;
            cur_state     = ST_FAULT;
            phase_start   = '0;
            shown_mask    = COL_OFF;
            shown_valid   = 1'b0;
            forced_on     = 1'b0;
            forced_mask   = COL_OFF;
            echo_seen     = '0;
            advance_time  = '0;
            advance_armed = 1'b0;
        end
        else
        begin
            if (took)
                led_expect_q.push_back(next_led(shown_req));
            if ((took || !in_if.valid) && request_q.size() != 0
                && $urandom_range(0, 99) >= send_idle_pct)
            begin
                shown_req = request_q.pop_front();
                in_if.op              <= shown_req.op;
                in_if.now_ms          <= shown_req.now_ms;
                in_if.radio_active    <= shown_req.radio_active;
                in_if.link_ready      <= shown_req.link_ready;
                in_if.is_advertising  <= shown_req.is_advertising;
                in_if.peer_connected  <= shown_req.peer_connected;
                in_if.echo_count      <= shown_req.echo_count;
                in_if.override_auto   <= shown_req.override_auto;
                in_if.override_colour <= shown_req.override_colour;
                in_if.valid           <= 1'b1;
            end
            else if (took)
            begin
                in_if.valid <= 1'b0;
            end
        end
    end

    // result monitor
    always @(posedge clk)
    begin
        led_result_t got;
        led_result_t want;
        if (!rst_n)
        begin
            out_if.ready <= 1'b0;
            mismatches = 0;
            result_idx = 0;
        end
        else
        begin
            if (out_if.valid && out_if.ready)
            begin
                got.led_colour      = out_if.led_colour;
                got.led_write       = out_if.led_write;
                got.link_state      = out_if.link_state;
                got.override_active = out_if.override_active;
                if (led_expect_q.size() == 0)
                begin
                    if (mismatches + cfg_errors < 10)
                        $display("result %0d: unexpected result", result_idx);
                    mismatches++;
                end
                else
                begin
                    want = led_expect_q.pop_front();
                    if (got !== want)
                    begin
                        if (mismatches + cfg_errors < 10)
                            $display("result %0d: expected colour %0d write %0b ", result_idx,
                                     want.led_colour, want.led_write,
                                     "state %0d override %0b, ", want.link_state,
                                     want.override_active,
                                     "got colour %0d write %0b ", got.led_colour,
                                     got.led_write,
                                     "state %0d override %0b", got.link_state,
                                     got.override_active);
                        mismatches++;
                    end
                end
                result_idx++;
            end
            out_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    task automatic push_tick(input logic [31:0] now, input logic radio, input logic lready,
                             input logic adv, input logic peer, input logic [31:0] echo);
        link_req_t r;
        r.op              = OP_TICK;
        r.now_ms          = now;
        r.radio_active    = radio;
        r.link_ready      = lready;
        r.is_advertising  = adv;
        r.peer_connected  = peer;
        r.echo_count      = echo;
        r.override_auto   = 1'($urandom_range(0, 1));
        r.override_colour = 8'($urandom_range(0, 255));
        request_q.push_back(r);
    endtask

    task automatic push_override(input logic to_auto, input logic [7:0] colour,
                                 input logic [31:0] now);
        link_req_t r;
        r.op              = OP_OVERRIDE;
        r.now_ms          = now;
        r.radio_active    = 1'($urandom_range(0, 1));
        r.link_ready      = 1'($urandom_range(0, 1));
        r.is_advertising  = 1'($urandom_range(0, 1));
        r.peer_connected  = 1'($urandom_range(0, 1));
        r.echo_count      = $urandom;
        r.override_auto   = to_auto;
        r.override_colour = colour;
        request_q.push_back(r);
    endtask

    task automatic queue_random(input int n);
        int unsigned pick;
        logic        radio;
        logic        lready;
        logic        adv;
        logic        peer;
        for (int i = 0; i < n; i++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 55)
                stim_now = stim_now + $urandom_range(0, 30);
            else if (pick < 80)
                stim_now = stim_now + $urandom_range(31, 600);
            else if (pick < 93)
                stim_now = stim_now + $urandom_range(601, 8000);
            else if (pick < 98)
                stim_now = stim_now + $urandom_range(8001, 70000);
            else
                stim_now = $urandom;

            if ($urandom_range(0, 99) < 7)
            begin
                push_override($urandom_range(0, 99) < 60, 8'($urandom_range(0, 255)),
                              stim_now);
                continue;
            end

            if ($urandom_range(0, 99) < 6)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 10)
                    link_mode = ST_FAULT;
                else if (pick < 25)
                    link_mode = ST_INVISIBLE;
                else if (pick < 40)
                    link_mode = ST_ADVERTISING;
                else if (pick < 55)
                    link_mode = ST_LINKING;
                else
                    link_mode = ST_READY;
                pick = $urandom_range(0, 2);
                echo_rate = (pick == 0) ? 0 : (pick == 1) ? 5 : 30;
            end

            adv  = 1'($urandom_range(0, 1));
            peer = 1'($urandom_range(0, 1));
            case (link_mode)
                ST_FAULT:       begin radio = 1'b0; lready = 1'($urandom_range(0, 1)); end
                ST_INVISIBLE:   begin radio = 1'b1; lready = 1'b0; adv = 1'b0; peer = 1'b0; end
                ST_ADVERTISING: begin radio = 1'b1; lready = 1'b0; peer = 1'b0; adv = 1'b1; end
                ST_LINKING:     begin radio = 1'b1; lready = 1'b0; peer = 1'b1; end
                default:        begin radio = 1'b1; lready = 1'b1; end
            endcase
            // occasional stray flags
            if ($urandom_range(0, 99) < 4)
            begin
                radio  = 1'($urandom_range(0, 1));
                lready = 1'($urandom_range(0, 1));
            end

            pick = $urandom_range(0, 99);
            if (pick < 3)
                stim_echo = $urandom;
            else if (pick < 3 + echo_rate)
                stim_echo = stim_echo + $urandom_range(1, 3);

            push_tick(stim_now, radio, lready, adv, peer, stim_echo);
        end
    endtask

    task automatic apb_access(input logic wr, input logic [2:0] addr, input logic [31:0] wdata,
                              output logic [31:0] rdata);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic wait_drained();
        do
            @(negedge clk);
        while (request_q.size() != 0 || in_if.valid || led_expect_q.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic next_phase(input logic [LIMIT_BITS-1:0] limit, input int unsigned send_pct,
                              input int unsigned recv_pct);
        logic [31:0] rd;
        wait_drained();
        apb_access(1'b1, STALL_LIMIT_ADDR, {16'd0, limit}, rd);
        stall_limit = limit;
        apb_access(1'b0, STALL_LIMIT_ADDR, 32'd0, rd);
        if (rd[LIMIT_BITS-1:0] !== limit)
        begin
            if (mismatches + cfg_errors < 10)
                $display("stall_limit_ms readback: expected %0d, got %0d", limit,
                         rd[LIMIT_BITS-1:0]);
            cfg_errors++;
        end
        @(negedge clk);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
    endtask

    initial
    begin
        clk            = 1'b0;
        rst_n          = 1'b0;
        send_idle_pct  = 26;
        recv_stall_pct = 76;
        cfg_errors     = 0;

        stall_limit   = STALL_LIMIT_RESET;

        stim_now  = $urandom;
        stim_echo = $urandom;
        link_mode = ST_READY;
        echo_rate = 30;

        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= '0;
        pwdata  <= '0;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // blink phases of fault, then each link class
        push_tick(32'd0,   1'b0, 1'b0, 1'b0, 1'b0, 32'd0);
        push_tick(32'd150, 1'b0, 1'b0, 1'b0, 1'b0, 32'd0);
        push_tick(32'd250, 1'b0, 1'b0, 1'b0, 1'b0, 32'd0);
        push_tick(32'd300, 1'b1, 1'b0, 1'b0, 1'b0, 32'd0);
        push_tick(32'd400, 1'b1, 1'b0, 1'b1, 1'b0, 32'd0);
        push_tick(32'd405, 1'b1, 1'b0, 1'b1, 1'b0, 32'd0);
        push_tick(32'd409, 1'b1, 1'b0, 1'b1, 1'b0, 32'd0);
        push_tick(32'd500, 1'b1, 1'b0, 1'b1, 1'b1, 32'd0);
        // fresh link arms the stall detector, then limit edge
        push_tick(32'd600,  1'b1, 1'b1, 1'b0, 1'b0, 32'd0);
        push_tick(32'd5600, 1'b1, 1'b1, 1'b0, 1'b0, 32'd0);
        push_tick(32'd5601, 1'b1, 1'b1, 1'b0, 1'b0, 32'd0);
        push_tick(32'd5700, 1'b1, 1'b1, 1'b0, 1'b0, 32'd7);
        // forced colours, upper colour bits ignored
        push_override(1'b0, 8'hFD, 32'd5750);
        push_tick(32'd5800, 1'b0, 1'b0, 1'b0, 1'b0, 32'd7);
        push_override(1'b0, 8'hFA, 32'd5850);
        push_tick(32'd5900, 1'b1, 1'b1, 1'b1, 1'b1, 32'd7);
        push_override(1'b1, 8'h00, 32'd6000);
        push_tick(32'd6000, 1'b1, 1'b1, 1'b0, 1'b0, 32'd7);
        // time going backwards, radio loss keeps detector, not-ready disarms
        push_tick(32'd100, 1'b1, 1'b1, 1'b0, 1'b0, 32'd7);
        push_tick(32'd200, 1'b0, 1'b1, 1'b0, 1'b0, 32'd7);
        push_tick(32'd300, 1'b1, 1'b1, 1'b0, 1'b0, 32'd7);
        push_tick(32'd400, 1'b1, 1'b0, 1'b0, 1'b0, 32'd7);
        push_tick(32'hFFFF_FFF0, 1'b1, 1'b1, 1'b1, 1'b1, 32'hFFFF_FFFF);
        push_tick(32'h0000_0005, 1'b1, 1'b1, 1'b1, 1'b1, 32'hFFFF_FFFF);
        push_override(1'b1, 8'hFF, 32'hFFFF_FFFF);

        queue_random(100);
        next_phase(16'd1, 26, 76);
        queue_random(125);
        next_phase(16'd65535, 76, 26);
        queue_random(125);
        next_phase(16'd0, 76, 26);
        queue_random(100);
        next_phase(LIMIT_BITS'($urandom_range(1, 65535)), 0, 0);
        queue_random(100);
        next_phase(STALL_LIMIT_RESET, 0, 0);
        queue_random(75);

        wait_drained();
        repeat (60) @(posedge clk);
        if (mismatches == 0 && cfg_errors == 0 && led_expect_q.size() == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule
